// ===== sv/cartesian_to_latlong_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Cartesian to latitude/longitude converter
// Each macro expands to a clocked concurrent assertion in simulation and to
// nothing in synthesis. The assertions sample on clk_i and are disabled while
// rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_LATLONG_DEFINES_SVH
`define CARTESIAN_TO_LATLONG_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define C2LL_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("c2ll assertion failed");
// Next-cycle implication.
`define C2LL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("c2ll assertion failed");
`else
`define C2LL_ASSERT(lbl, pre, post)
`define C2LL_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== sv/c2ll_pkg.sv =====
// ----------------------------------------------------------------------------
// c2ll_pkg
// Constants for the Cartesian to latitude/longitude converter: stage counts,
// angle constants and the CORDIC arctangent table (units of 2^-24 degree).
// ----------------------------------------------------------------------------
`default_nettype none

package c2ll_pkg;

  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CW           = 36;  // CORDIC vector width
  localparam int unsigned AW           = 34;  // angle width

  localparam logic [14:0] RADIUS_RESET = 15'd6367;

  localparam logic signed [AW-1:0] DEG90  = AW'(64'sd90  <<< 24);
  localparam logic signed [AW-1:0] DEG180 = AW'(64'sd180 <<< 24);

  localparam logic signed [24:0] LON_90  = 25'sd5898240;
  localparam logic signed [24:0] LON_180 = 25'sd11796480;
  localparam logic signed [23:0] LAT_90  = 24'sd5898240;

  localparam logic [31:0] ATAN_LUT [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
    32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
    32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
    32'd234684,    32'd117342,    32'd58671,     32'd29335,
    32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  // Per-item flags and operands that ride along the pipeline.
  typedef struct packed {
    logic [23:0] ax;
    logic [23:0] ay;
    logic        xneg;
    logic        xzero;
    logic        yneg;
    logic        yzero;
    logic        zneg;
    logic        off;
    logic        szero;
  } side_t;

  // Clamp an angle to [0, 90] degrees and round to 1/65536 degree.
  function automatic logic [23:0] round_angle(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] c;
    logic signed [AW-1:0] r;
    c = a;
    if (a < 0) c = '0;
    if (a > DEG90) c = DEG90;
    r = (c + AW'(128)) >>> 8;
    return r[23:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cartesian_to_latlong.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_latlong
// Converts a Cartesian point (x, y, z in 1/256 km) to longitude and latitude
// in 1/65536 degree on a sphere of programmable radius.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive as beats on the s_axis channel and one result beat leaves on
//   the m_axis channel for each of them, in order. A beat is taken whenever
//   tvalid and tready are high at a rising edge of clk_i.
//   The radius register sits at byte address 0 of the APB port; write it only
//   while no point is in flight.
//   The pipeline holds 60 register stages, from the input capture register to
//   the output register that drives m_axis_tvalid.
//   Throughput is one point per cycle while the output is not stalled: two
//   32-step restoring square-root pipelines (one root bit per stage) feed two
//   24-stage vectoring CORDIC pipelines (one rotation per stage), and every
//   stage takes a new point each cycle unless the pipeline is frozen.
//   When the receiver holds m_axis_tready low with a result waiting, the
//   whole pipeline freezes and s_axis_tready drops in the same cycle; nothing
//   is lost or repeated.
//   Reset clears all valid bits and loads the radius with 6367 km.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cartesian_to_latlong_defines.svh"

module cartesian_to_latlong
  import c2ll_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input beats
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // coord_x[23:0], coord_y[47:24], coord_z[71:48]
  // Output beats
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,  // longitude[24:0], latitude[48:25], zero fill
  output logic [0:0]       m_axis_tuser   // off_sphere[0]
);

  logic en;

  // Radius register.
  logic [14:0] radius_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      radius_q <= pwdata[14:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {17'd0, radius_q} : 32'd0;

  // Global advance: the output register is free or is being emptied.
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: capture the input beat.
  logic               v1_q;
  logic signed [23:0] x1_q, y1_q;
  logic               zneg1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q    <= s_axis_tdata[23:0];
      y1_q    <= s_axis_tdata[47:24];
      zneg1_q <= s_axis_tdata[71];
    end
  end

  // Stage 2: magnitudes and squares.
  logic [23:0] ax1, ay1;
  assign ax1 = x1_q[23] ? 24'(-x1_q) : 24'(x1_q);
  assign ay1 = y1_q[23] ? 24'(-y1_q) : 24'(y1_q);

  logic        v2_q;
  logic [47:0] sqx2_q, sqy2_q;
  logic [29:0] r2_q;
  side_t       sd2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx2_q      <= ax1 * ax1;
      sqy2_q      <= ay1 * ay1;
      r2_q        <= radius_q * radius_q;
      sd2_q.ax    <= ax1;
      sd2_q.ay    <= ay1;
      sd2_q.xneg  <= x1_q[23];
      sd2_q.xzero <= (x1_q == '0);
      sd2_q.yneg  <= y1_q[23];
      sd2_q.yzero <= (y1_q == '0);
      sd2_q.zneg  <= zneg1_q;
      sd2_q.off   <= 1'b0;
      sd2_q.szero <= 1'b0;
    end
  end

  // Stage 3: horizontal distance squared against the radius squared.
  logic [47:0] s2;
  logic [47:0] d2;
  logic        off2;
  side_t       sd0;
  assign s2   = sqx2_q + sqy2_q;
  assign d2   = {2'b00, r2_q, 16'd0};
  assign off2 = s2 > d2;

  // Side data entering the root pipeline, with the distance flags filled in.
  always_comb begin
    sd0       = sd2_q;
    sd0.off   = off2;
    sd0.szero = (s2 == '0);
  end

  logic        sv_q [0:SQRT_STEPS];
  side_t       sd_q [0:SQRT_STEPS];
  logic [63:0] av_q [0:SQRT_STEPS];
  logic [63:0] ar_q [0:SQRT_STEPS];
  logic [63:0] bv_q [0:SQRT_STEPS];
  logic [63:0] br_q [0:SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0]       <= sd0;
      av_q[0]       <= {2'b00, s2, 14'd0};
      ar_q[0]       <= '0;
      bv_q[0]       <= off2 ? 64'd0 : {2'b00, 48'(d2 - s2), 14'd0};
      br_q[0]       <= '0;
    end
  end

  // Square-root pipeline: one root bit per stage for both operands.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] at, bt;
    assign at = ar_q[k] + BIT;
    assign bt = br_q[k] + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else if (en) sv_q[k+1] <= sv_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sd_q[k+1] <= sd_q[k];
        if (av_q[k] >= at) begin
          av_q[k+1] <= av_q[k] - at;
          ar_q[k+1] <= (ar_q[k] >> 1) + BIT;
        end else begin
          av_q[k+1] <= av_q[k];
          ar_q[k+1] <= ar_q[k] >> 1;
        end
        if (bv_q[k] >= bt) begin
          bv_q[k+1] <= bv_q[k] - bt;
          br_q[k+1] <= (br_q[k] >> 1) + BIT;
        end else begin
          bv_q[k+1] <= bv_q[k];
          br_q[k+1] <= br_q[k] >> 1;
        end
      end
    end
  end

  // CORDIC entry operands.
  logic signed [CW-1:0] lx0, ly0, tx0, ty0;
  logic                 tpyz0;
  assign lx0   = CW'({sd_q[SQRT_STEPS].ax, 8'd0});
  assign ly0   = CW'({sd_q[SQRT_STEPS].ay, 8'd0});
  assign tx0   = CW'(ar_q[SQRT_STEPS][31:0]);
  assign ty0   = CW'(br_q[SQRT_STEPS][31:0]);
  assign tpyz0 = (br_q[SQRT_STEPS][31:0] == 32'd0);

  logic                 cv_q  [0:CORDIC_STEPS-1];
  side_t                cs_q  [0:CORDIC_STEPS-1];
  logic                 cpz_q [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] lx_q  [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] ly_q  [0:CORDIC_STEPS-1];
  logic signed [AW-1:0] lz_q  [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] tx_q  [0:CORDIC_STEPS-1];
  logic signed [CW-1:0] ty_q  [0:CORDIC_STEPS-1];
  logic signed [AW-1:0] tz_q  [0:CORDIC_STEPS-1];

  // Vectoring CORDIC pipelines, one rotation per stage, for both angles.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ATN = AW'(ATAN_LUT[i]);
    logic                 vin, pzin;
    side_t                sin;
    logic signed [CW-1:0] lxi, lyi, txi, tyi;
    logic signed [AW-1:0] lzi, tzi;

    if (i == 0) begin : g_first
      assign vin  = sv_q[SQRT_STEPS];
      assign sin  = sd_q[SQRT_STEPS];
      assign pzin = tpyz0;
      assign lxi  = lx0;
      assign lyi  = ly0;
      assign lzi  = '0;
      assign txi  = tx0;
      assign tyi  = ty0;
      assign tzi  = '0;
    end else begin : g_next
      assign vin  = cv_q[i-1];
      assign sin  = cs_q[i-1];
      assign pzin = cpz_q[i-1];
      assign lxi  = lx_q[i-1];
      assign lyi  = ly_q[i-1];
      assign lzi  = lz_q[i-1];
      assign txi  = tx_q[i-1];
      assign tyi  = ty_q[i-1];
      assign tzi  = tz_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i] <= 1'b0;
      else if (en) cv_q[i] <= vin;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        cs_q[i]  <= sin;
        cpz_q[i] <= pzin;
        if (!lyi[CW-1]) begin
          lx_q[i] <= lxi + (lyi >>> i);
          ly_q[i] <= lyi - (lxi >>> i);
          lz_q[i] <= lzi + ATN;
        end else begin
          lx_q[i] <= lxi - (lyi >>> i);
          ly_q[i] <= lyi + (lxi >>> i);
          lz_q[i] <= lzi - ATN;
        end
        if (!tyi[CW-1]) begin
          tx_q[i] <= txi + (tyi >>> i);
          ty_q[i] <= tyi - (txi >>> i);
          tz_q[i] <= tzi + ATN;
        end else begin
          tx_q[i] <= txi - (tyi >>> i);
          ty_q[i] <= tyi + (txi >>> i);
          tz_q[i] <= tzi - ATN;
        end
      end
    end
  end

  // Final stage: clamp, round and resolve the axis and off-sphere cases.
  localparam int unsigned LAST = CORDIC_STEPS - 1;
  side_t                fs;
  logic signed [AW-1:0] lonc, lona, lonr;
  logic signed [24:0]   lon_d;
  logic signed [23:0]   latm, lat_d;

  assign fs = cs_q[LAST];

  always_comb begin
    lonc = lz_q[LAST];
    if (lonc < 0) lonc = '0;
    if (lonc > DEG90) lonc = DEG90;
    lona = fs.xneg ? (DEG180 - lonc) : lonc;
    lonr = (lona + AW'(128)) >>> 8;
    if (fs.xzero) begin
      lon_d = fs.yzero ? 25'sd0 : (fs.yneg ? -LON_90 : LON_90);
    end else if (fs.yzero) begin
      lon_d = fs.xneg ? LON_180 : 25'sd0;
    end else begin
      lon_d = fs.yneg ? -lonr[24:0] : lonr[24:0];
    end

    if (fs.off) begin
      latm = '0;
    end else if (fs.szero) begin
      latm = LAT_90;
    end else if (cpz_q[LAST]) begin
      latm = '0;
    end else begin
      latm = round_angle(tz_q[LAST]);
    end
    lat_d = fs.zneg ? -latm : latm;
  end

  // Output register.
  logic signed [24:0] lon_q;
  logic signed [23:0] lat_q;
  logic               off_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= cv_q[LAST];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lon_q <= lon_d;
      lat_q <= lat_d;
      off_q <= fs.off;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, lat_q, lon_q};
  assign m_axis_tuser  = off_q;

  // Checks.
  `C2LL_ASSERT(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `C2LL_ASSERT(a_off_lat_zero, m_axis_tvalid && m_axis_tuser[0], lat_q == '0)
  `C2LL_ASSERT(a_lon_range, m_axis_tvalid, (lon_q <= LON_180) && (lon_q >= -LON_180))
  `C2LL_ASSERT_NEXT(a_stall_freeze, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(lon_q) && $stable(lat_q))

endmodule

`default_nettype wire
